### sv/palette_match_planar_tile_encoder_top_defines.svh
// Assertion macros for the palette-matching planar tile encoder.
// Used by the checker; expects clk and arst_n in the enclosing scope.
`ifndef PALETTE_MATCH_PLANAR_TILE_ENCODER_TOP_DEFINES_SVH
`define PALETTE_MATCH_PLANAR_TILE_ENCODER_TOP_DEFINES_SVH

// Condition in one cycle implies a condition in the next.
`define PMPT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pmpt: next-cycle check failed");

// Signal holds its value across a stalled cycle.
`define PMPT_ASSERT_HOLD(lbl, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error("pmpt: stalled payload changed");

`endif

### sv/pmpt_pkg.sv
// Shared types and constants for the palette-matching planar tile encoder.
// No dependencies.
`timescale 1ns / 1ps

package pmpt_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int CODE_W = 8;
	localparam int RGB_W = 24;
	localparam int ENTRY_W = 8;

	localparam logic FUNC_PALETTE = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// Code for one pixel, handed from the search unit to the tile buffer
	typedef struct packed {
		logic done;
		logic [CODE_W-1:0] code;
	} pmpt_code_t;

endpackage

### sv/pmpt_search.sv
// Colour table memory with valid bits and the first-match search sequencer.
// Depends on pmpt_pkg.
`timescale 1ns / 1ps

module pmpt_search #(
	parameter int PALETTE_ENTRIES = pmpt_pkg::PALETTE_ENTRIES_DEF,
	localparam int IDX_W = $clog2(PALETTE_ENTRIES)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [pmpt_pkg::RGB_W-1:0] wr_rgb,
	input  logic start,
	input  logic [pmpt_pkg::RGB_W-1:0] pix_rgb,
	output pmpt_pkg::pmpt_code_t res
);
	import pmpt_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
	localparam logic [CODE_W-1:0] MISS_CODE =
		(PALETTE_ENTRIES + 1 > 255) ? 8'd255 : CODE_W'(PALETTE_ENTRIES + 1);

	logic [RGB_W-1:0] pal_mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;

	logic busy_q, issued_q;
	logic [IDX_W-1:0] addr_q;
	logic [RGB_W-1:0] pix_q;
	logic cmp_s1, vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [RGB_W-1:0] rd_s1;
	pmpt_code_t res_q;

	logic hit, miss, issue;
	logic [CODE_W:0] hit_sum;
	logic [CODE_W-1:0] hit_code;

	assign issue = busy_q && !issued_q;
	assign hit = cmp_s1 && ((vld_s1 ? rd_s1 : '0) == pix_q);
	assign miss = cmp_s1 && !hit && (idx_s1 == LAST_IDX);
	assign hit_sum = (CODE_W + 1)'(idx_s1) + 1'b1;
	assign hit_code = hit_sum[CODE_W] ? 8'd255 : hit_sum[CODE_W-1:0];
	assign res = res_q;

	// Colour table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pal_mem[wr_idx] <= wr_rgb;
		end
		rd_s1 <= pal_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pix_q <= pix_rgb;
		end
		idx_s1 <= addr_q;
		vld_s1 <= pal_vld_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
			busy_q <= 1'b0;
			issued_q <= 1'b0;
			addr_q <= '0;
			cmp_s1 <= 1'b0;
			res_q <= '0;
		end else begin
			res_q.done <= 1'b0;
			if (wr_en) begin
				pal_vld_q[wr_idx] <= 1'b1;
			end
			cmp_s1 <= issue;
			if (issue) begin
				if (addr_q == LAST_IDX) begin
					issued_q <= 1'b1;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (hit || miss) begin
				busy_q <= 1'b0;
				cmp_s1 <= 1'b0;
				res_q.done <= 1'b1;
				res_q.code <= hit ? hit_code : MISS_CODE;
			end
			if (start) begin
				busy_q <= 1'b1;
				issued_q <= 1'b0;
				addr_q <= '0;
				cmp_s1 <= 1'b0;
			end
		end
	end

endmodule

### sv/pmpt_tile.sv
// Tile buffer memory (eight rows of eight codes) and the bitplane emitter
// with its output register. Depends on pmpt_pkg.
`timescale 1ns / 1ps

module pmpt_tile (
	input  logic clk,
	input  logic arst_n,
	input  pmpt_pkg::pmpt_code_t code_in,
	input  logic out_stall,
	output logic out_valid,
	output logic [7:0] plane_byte,
	output logic tile_last,
	output logic done
);
	import pmpt_pkg::*;

	localparam int ROW_W = 8 * CODE_W;

	typedef enum logic [1:0] {E_IDLE, E_READ, E_P0, E_P1} emit_st_t;

	logic [ROW_W-1:0] tile_mem [8];
	logic [ROW_W-1:0] row_q, row_wr, rd_row_q;
	logic [5:0] cnt_q;
	logic [2:0] y_q;
	logic [1:0] g_q;
	emit_st_t st_q;
	logic ov_q, last_q, done_q;
	logic [7:0] byte_q;
	logic out_free, row_we, end_tile;

	function automatic logic [7:0] plane_bits(input logic [ROW_W-1:0] row,
		input logic [2:0] plane);
		logic [7:0] b;
		for (int x = 0; x < 8; x++) begin
			b[7-x] = row[x*CODE_W + int'(plane)];
		end
		return b;
	endfunction

	assign out_free = !ov_q || !out_stall;
	assign row_we = code_in.done && (cnt_q[2:0] == 3'd7);
	assign end_tile = (g_q == 2'd3) && (y_q == 3'd7);
	assign out_valid = ov_q;
	assign plane_byte = byte_q;
	assign tile_last = last_q;
	assign done = done_q;

	always_comb begin
		row_wr = row_q;
		row_wr[int'(cnt_q[2:0])*CODE_W +: CODE_W] = code_in.code;
	end

	always_ff @(posedge clk) begin
		if (code_in.done) begin
			row_q <= row_wr;
		end
		if (row_we) begin
			tile_mem[cnt_q[5:3]] <= row_wr;
		end
		rd_row_q <= tile_mem[y_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			cnt_q <= '0;
			y_q <= '0;
			g_q <= '0;
			ov_q <= 1'b0;
			last_q <= 1'b0;
			byte_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				E_IDLE: begin
					if (code_in.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 6'd63) begin
							st_q <= E_READ;
							y_q <= '0;
							g_q <= '0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				E_READ: begin
					st_q <= E_P0;
				end
				E_P0: begin
					if (out_free) begin
						ov_q <= 1'b1;
						byte_q <= plane_bits(rd_row_q, {g_q, 1'b0});
						last_q <= 1'b0;
						st_q <= E_P1;
					end
				end
				E_P1: begin
					if (out_free) begin
						ov_q <= 1'b1;
						byte_q <= plane_bits(rd_row_q, {g_q, 1'b1});
						last_q <= end_tile;
						if (end_tile) begin
							st_q <= E_IDLE;
							done_q <= 1'b1;
						end else begin
							st_q <= E_READ;
							y_q <= y_q + 1'b1;
							if (y_q == 3'd7) begin
								g_q <= g_q + 1'b1;
							end
						end
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

endmodule

### sv/palette_match_planar_tile_encoder_top.sv
// Top level of the palette-matching planar tile encoder.
// Depends on pmpt_pkg, pmpt_search and pmpt_tile.
//
// Input channel (in_valid/in_stall): func 0 writes a colour table entry
// (entries at or above PALETTE_ENTRIES are dropped); func 1 is one pixel
// of an 8x8 tile, row by row, left to right. Output channel
// (out_valid/out_stall): 64 bitplane bytes per tile, planes paired per
// group, tile_last on the final byte.
// A table write leaves in_stall low. A pixel reads the table one entry a
// cycle through its single read port, up to the first hit or, on a miss,
// the last entry. The 64th pixel then drains the tile buffer one row read
// per byte pair.
// in_stall is high from a pixel transfer until that pixel is stored, or
// until the last byte of its tile sits in the output register.
// Reset clears the colour table to zero (valid bits), the pixel count and
// the output register. A stalled receiver holds the output register and
// the emitter waits; the input side then stays stalled.
`timescale 1ns / 1ps

module palette_match_planar_tile_encoder_top #(
	parameter int PALETTE_ENTRIES = pmpt_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	input  logic [pmpt_pkg::ENTRY_W-1:0] entry_index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] plane_byte,
	output logic tile_last
);
	import pmpt_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	logic pend_q, in_xfer, pal_we, pix_start, tile_done;
	logic [RGB_W-1:0] rgb;
	pmpt_code_t code;

	assign in_stall = pend_q;
	assign in_xfer = in_valid && !pend_q;
	assign rgb = {red, green, blue};
	assign pal_we = in_xfer && (func == FUNC_PALETTE)
		&& ((ENTRY_W + 1)'(entry_index) < (ENTRY_W + 1)'(PALETTE_ENTRIES));
	assign pix_start = in_xfer && (func == FUNC_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (pix_start) begin
			pend_q <= 1'b1;
		end else if (tile_done) begin
			pend_q <= 1'b0;
		end
	end

	pmpt_search #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (pal_we),
		.wr_idx (entry_index[IDX_W-1:0]),
		.wr_rgb (rgb),
		.start  (pix_start),
		.pix_rgb(rgb),
		.res    (code)
	);

	pmpt_tile u_tile (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_in   (code),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.plane_byte(plane_byte),
		.tile_last (tile_last),
		.done      (tile_done)
	);

endmodule

### sv/pmpt_checker.sv
// Port-level checks for the palette-matching planar tile encoder, and the
// bind that attaches them. Depends on the top level and the defines header.
`timescale 1ns / 1ps
`include "palette_match_planar_tile_encoder_top_defines.svh"

module pmpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic func,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] plane_byte,
	input logic tile_last
);

	// a pixel transfer always blocks the item after it
	`PMPT_ASSERT_NEXT(a_pix_blocks, in_valid && !in_stall && func, in_stall)
	// a table write leaves the input open
	`PMPT_ASSERT_NEXT(a_pal_open, in_valid && !in_stall && !func, !in_stall)
	// nothing follows the final byte of a tile until another tile arrives
	`PMPT_ASSERT_NEXT(a_last_drains, out_valid && !out_stall && tile_last, !out_valid)
	`PMPT_ASSERT_HOLD(a_out_hold, out_valid && out_stall, {out_valid, plane_byte, tile_last})

endmodule

bind palette_match_planar_tile_encoder_top pmpt_checker u_pmpt_checker (.*);

### sim/pmpt_tile_checker.sv
// Checker for the palette-matching planar tile encoder: watches both channels,
// predicts the bitplane bytes of each tile and compares them in order.
// Depends on pmpt_pkg.
`timescale 1ns / 1ps

module pmpt_tile_checker #(
	parameter int PALETTE_ENTRIES = pmpt_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic func,
	input  logic [pmpt_pkg::ENTRY_W-1:0] entry_index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [7:0] plane_byte,
	input  logic tile_last,
	output int fail_count,
	output int pending_bytes,
	output int bytes_checked
);

	localparam int CODE_MAX = (1 << pmpt_pkg::CODE_W) - 1;
	localparam int TABLE_DEPTH = 256;
	localparam int TILE_PIXELS = 64;

	typedef struct packed {
		logic [7:0] plane_byte;
		logic tile_last;
	} planar_byte_t;

	logic [pmpt_pkg::RGB_W-1:0] colour_table [TABLE_DEPTH];
	logic [pmpt_pkg::CODE_W-1:0] tile_codes [TILE_PIXELS];
	logic [5:0] pixel_count;
	planar_byte_t expected_planes [$];

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		int e;
		int hit;
		int code;
		int grp;
		int row;
		int pl;
		int col;
		logic [7:0] acc;
		planar_byte_t want;
		if (!arst_n) begin
			for (e = 0; e < TABLE_DEPTH; e++)
				colour_table[e] = '0;
			for (e = 0; e < TILE_PIXELS; e++)
				tile_codes[e] = '0;
			pixel_count = '0;
			expected_planes.delete();
			fail_count = 0;
			pending_bytes = 0;
			bytes_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_planes.size() == 0) begin
					$display("%0t: unexpected plane byte: expected none, actual %02h last %0b",
						$time, plane_byte, tile_last);
					fail_count++;
				end else begin
					want = expected_planes.pop_front();
					pending_bytes--;
					bytes_checked++;
					if (plane_byte !== want.plane_byte) begin
						$display("%0t: plane_byte mismatch: expected %02h, actual %02h",
							$time, want.plane_byte, plane_byte);
						fail_count++;
					end
					if (tile_last !== want.tile_last) begin
						$display("%0t: tile_last mismatch: expected %0b, actual %0b",
							$time, want.tile_last, tile_last);
						fail_count++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (func == pmpt_pkg::FUNC_PALETTE) begin
					// writes past the configured table are dropped
					if (entry_index < PALETTE_ENTRIES)
						colour_table[entry_index] = {red, green, blue};
				end else begin
					// scan downwards so the lowest matching entry wins
					hit = PALETTE_ENTRIES;
					for (e = PALETTE_ENTRIES - 1; e >= 0; e--)
						if (colour_table[e] == {red, green, blue})
							hit = e;
					code = (hit + 1 > CODE_MAX) ? CODE_MAX : hit + 1;
					tile_codes[pixel_count] = code[pmpt_pkg::CODE_W-1:0];
					if (pixel_count == 6'd63) begin
						for (grp = 0; grp < 4; grp++)
							for (row = 0; row < 8; row++)
								for (pl = 0; pl < 2; pl++) begin
									acc = '0;
									for (col = 0; col < 8; col++)
										acc[7 - col] = tile_codes[row * 8 + col][2 * grp + pl];
									want.plane_byte = acc;
									want.tile_last = (grp == 3 && row == 7 && pl == 1);
									expected_planes.push_back(want);
									pending_bytes++;
								end
						pixel_count = '0;
					end else begin
						pixel_count++;
					end
				end
			end
		end
	end

endmodule

### sim/tb_top.sv
// Top of the tile encoder bench: clock, reset, stimulus and the verdict.
// Depends on pmpt_pkg, palette_match_planar_tile_encoder_top and pmpt_tile_checker.
`timescale 1ns / 1ps

module tb_top;

	localparam int PAL_ENTRIES = pmpt_pkg::PALETTE_ENTRIES_DEF;
	localparam int LONG_HOLD = 200;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic [pmpt_pkg::ENTRY_W-1:0] entry_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic out_valid;
	logic out_stall;
	logic [7:0] plane_byte;
	logic tile_last;

	int fail_count;
	int pending_bytes;
	int bytes_checked;

	bit quiet;
	bit long_hold_done;
	int palette_writes;
	int pixels_sent;
	int sender_gaps;
	logic [23:0] known_rgb [$];

	palette_match_planar_tile_encoder_top #(
		.PALETTE_ENTRIES(PAL_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.entry_index(entry_index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.plane_byte(plane_byte),
		.tile_last(tile_last)
	);

	pmpt_tile_checker #(
		.PALETTE_ENTRIES(PAL_ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.entry_index(entry_index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.plane_byte(plane_byte),
		.tile_last(tile_last),
		.fail_count(fail_count),
		.pending_bytes(pending_bytes),
		.bytes_checked(bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("%0t: timeout, %0d plane bytes still expected", $time, pending_bytes);
		$display("simulation failed");
		$finish;
	end

	// Receiver: short random stall bursts, one long hold-off on the second tile
	initial begin : receiver
		int hold_left;
		int burst_left;
		hold_left = 0;
		burst_left = 0;
		long_hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (!long_hold_done && out_valid && bytes_checked >= 64) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_stall = 1'b1;
			end else if (quiet) begin
				out_stall = 1'b0;
			end else if (burst_left > 0) begin
				out_stall = 1'b1;
				burst_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				burst_left = $urandom_range(0, 2);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// One transfer on the input channel; returns at the falling edge after it
	task automatic send_item(input logic f, input logic [7:0] idx, input logic [23:0] rgb);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			sender_gaps++;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		entry_index = idx;
		{red, green, blue} = rgb;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (f == pmpt_pkg::FUNC_PALETTE) begin
			palette_writes++;
			known_rgb.push_back(rgb);
		end else begin
			pixels_sent++;
		end
	endtask

	task automatic send_pixel(input logic [23:0] rgb);
		send_item(pmpt_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)), rgb);
	endtask

	task automatic random_palette_write();
		logic [7:0] idx;
		// low entries keep the search short most of the time
		idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
		                                   : 8'($urandom_range(0, 255));
		send_item(pmpt_pkg::FUNC_PALETTE, idx, 24'($urandom));
	endtask

	task automatic random_tile(input int n_writes);
		int sent;
		int pick;
		repeat (n_writes) random_palette_write();
		sent = 0;
		while (sent < 64) begin
			if ($urandom_range(0, 11) == 0)
				random_palette_write();
			pick = $urandom_range(0, 19);
			if (pick < 14)
				send_pixel(known_rgb[$urandom_range(0, known_rgb.size() - 1)]);
			else if (pick < 17)
				send_pixel(24'($urandom));
			else
				send_pixel(24'h000000);
			sent++;
		end
	endtask

	initial begin : stimulus
		logic [23:0] fill_rgb [8];
		int k;
		int wait_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = pmpt_pkg::FUNC_PALETTE;
		entry_index = '0;
		red = '0;
		green = '0;
		blue = '0;
		quiet = 1'b0;
		palette_writes = 0;
		pixels_sent = 0;
		sender_gaps = 0;
		fill_rgb = '{24'h000000, 24'hFFFFFF, 24'h123456, 24'hA5C3E7,
		             24'h5A3C7E, 24'h010203, 24'h55AA55, 24'hAA55AA};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed tile: table fresh from reset, so black hits entry 0
		send_pixel(24'h000000);
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd0, 24'hFFFFFF);
		send_pixel(24'h000000);                 // now the first zero entry is 1
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd255, 24'h123456);
		send_pixel(24'h123456);                 // last entry, code clamps
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd254, 24'hA5C3E7);
		send_pixel(24'hA5C3E7);                 // code 255 without clamping
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd127, 24'h5A3C7E);
		send_pixel(24'h5A3C7E);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h010203);                 // no match anywhere
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd84, 24'h55AA55);
		send_pixel(24'h55AA55);
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd169, 24'hAA55AA);
		send_pixel(24'hAA55AA);
		send_item(pmpt_pkg::FUNC_PALETTE, 8'd200, 24'h5A3C7E);
		send_pixel(24'h5A3C7E);                 // duplicate colour, lower entry wins
		k = 0;
		while (pixels_sent % 64 != 0) begin
			send_pixel(fill_rgb[(k * 3) % 8]);
			k++;
		end

		// sender holds off until the whole tile has drained
		in_valid = 1'b0;
		while (pending_bytes != 0) @(negedge clk);

		random_tile(6);
		quiet = 1'b1;
		// a couple of table writes wait behind the draining tile
		repeat (2) random_palette_write();
		in_valid = 1'b0;

		wait_cycles = 0;
		while (pending_bytes != 0 && wait_cycles < 50000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (300) @(negedge clk);

		if (pending_bytes != 0)
			$display("%0t: %0d expected plane bytes never arrived", $time, pending_bytes);
		$display("covered %0d input transfers (%0d palette writes, %0d pixels), %0d bytes checked",
			palette_writes + pixels_sent, palette_writes, pixels_sent, bytes_checked);
		$display("sender gaps %0d, long receiver hold %0s", sender_gaps,
			long_hold_done ? "applied" : "not reached");
		if (fail_count == 0 && pending_bytes == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
